@@ src/ordered_list_positional_delete_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list with positional delete
// Shared immediate-style wrappers around concurrent property checks.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_POSITIONAL_DELETE_DEFINES_SVH
`define ORDERED_LIST_POSITIONAL_DELETE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define OLPD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("olpd invariant violated");
`define OLPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olpd sequence violated");
`else
`define OLPD_ASSERT_ALWAYS(label, clk, rst, cond)
`define OLPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/olpd_pkg.sv @@
// ----------------------------------------------------------------------------
// olpd_pkg
// Types and codes shared by the cell chain and its controller.
// ----------------------------------------------------------------------------
`default_nettype none

package olpd_pkg;

   localparam int CNT_W = 7;

   localparam logic [2:0] FUNC_APPEND     = 3'd0;
   localparam logic [2:0] FUNC_DEL_FIRST  = 3'd1;
   localparam logic [2:0] FUNC_DEL_LAST   = 3'd2;
   localparam logic [2:0] FUNC_DEL_POS    = 3'd3;
   localparam logic [2:0] FUNC_READ       = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_SHIFT  = 2'd1;
   localparam logic [1:0] OP_APPEND = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]       op;
      logic [CNT_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
   } olpd_ctl_type;

endpackage

`default_nettype wire

@@ src/olpd_cell.sv @@
// ----------------------------------------------------------------------------
// olpd_cell
// One list cell: shifts or rotates in a neighbor's value, or loads an append.
// ----------------------------------------------------------------------------
`default_nettype none

module olpd_cell #(
   parameter int IDX = 0
) (
   input  wire logic                  clock,
   input  wire olpd_pkg::olpd_ctl_type ctl,
   input  wire logic signed [31:0]    next_value,
   input  wire logic signed [31:0]    front_value,
   input  wire logic signed [31:0]    append_value,
   output logic signed [31:0]         value
);

   localparam logic [olpd_pkg::CNT_W-1:0] IDX_C = olpd_pkg::CNT_W'(IDX);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctl.op)
         olpd_pkg::OP_SHIFT: begin
            if (IDX_C >= ctl.idx) value_in = next_value;
         end
         olpd_pkg::OP_APPEND: begin
            if (IDX_C == ctl.cnt) value_in = append_value;
         end
         olpd_pkg::OP_ROTATE: begin
            if (IDX_C == ctl.cnt - 1'b1) value_in = front_value;
            else value_in = next_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

@@ src/ordered_list_positional_delete.sv @@
// ----------------------------------------------------------------------------
// ordered_list_positional_delete
// Bounded ordered list of signed values held in a chain of shifting cells.
// Append and delete respond from a register in the cycle after the request;
// a new request is taken every cycle the output drains and no read runs.
// A read out is accepted, then the chain rotates its front cell out, one
// element per response as the output drains; no request is taken meanwhile.
// Synchronous reset empties the list; cell contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_list_positional_delete_defines.svh"

module ordered_list_positional_delete #(
   parameter int CAPACITY = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_func,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic signed [15:0] req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_elem_value,
   output logic [6:0]              rsp_elem_count,
   output logic                    rsp_last_of_run
);

   localparam int CW = olpd_pkg::CNT_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_ff, rd_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic signed [31:0] elem_ff, elem_in;
   logic [CW-1:0]      ecount_ff, ecount_in;
   logic               last_ff, last_in;

   olpd_pkg::olpd_ctl_type ctl;
   logic signed [31:0]     cell_q [CAPACITY];
   logic                   out_free;
   logic                   req_fire;
   logic signed [15:0]     cnt_s;
   logic [CW-1:0]          del_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy_ff && out_free;
   assign req_fire  = req_valid && req_ready;
   assign cnt_s     = signed'({{(16 - CW){1'b0}}, count_ff});

   always_comb begin
      if (req_position <= 16'sd0) del_idx = '0;
      else if (req_position >= cnt_s) del_idx = count_ff - 1'b1;
      else del_idx = req_position[CW-1:0];
   end

   always_comb begin
      count_in     = count_ff;
      rd_in        = rd_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      elem_in      = elem_ff;
      ecount_in    = ecount_ff;
      last_in      = last_ff;
      ctl.op       = olpd_pkg::OP_HOLD;
      ctl.idx      = '0;
      ctl.cnt      = count_ff;

      if (busy_ff && out_free) begin
         ctl.op       = olpd_pkg::OP_ROTATE;
         rsp_valid_in = 1'b1;
         status_in    = olpd_pkg::STATUS_OK;
         elem_in      = cell_q[0];
         ecount_in    = count_ff;
         last_in      = (rd_ff == count_ff - 1'b1);
         rd_in        = rd_ff + 1'b1;
         if (rd_ff == count_ff - 1'b1) busy_in = 1'b0;
      end else if (req_fire) begin
         rsp_valid_in = 1'b1;
         status_in    = olpd_pkg::STATUS_OK;
         elem_in      = '0;
         last_in      = 1'b1;
         unique case (req_func) inside
            olpd_pkg::FUNC_APPEND: begin
               if (count_ff == CAP_C) begin
                  status_in = olpd_pkg::STATUS_FULL;
               end else begin
                  ctl.op   = olpd_pkg::OP_APPEND;
                  count_in = count_ff + 1'b1;
               end
            end
            olpd_pkg::FUNC_DEL_FIRST, olpd_pkg::FUNC_DEL_LAST,
            olpd_pkg::FUNC_DEL_POS: begin
               if (count_ff == '0) begin
                  status_in = olpd_pkg::STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
                  if (req_func == olpd_pkg::FUNC_DEL_FIRST) begin
                     ctl.op = olpd_pkg::OP_SHIFT;
                  end else if (req_func == olpd_pkg::FUNC_DEL_POS) begin
                     ctl.op  = olpd_pkg::OP_SHIFT;
                     ctl.idx = del_idx;
                  end
               end
            end
            olpd_pkg::FUNC_READ: begin
               if (count_ff == '0) begin
                  status_in = olpd_pkg::STATUS_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  busy_in      = 1'b1;
                  rd_in        = '0;
               end
            end
            default: status_in = olpd_pkg::STATUS_OK;
         endcase
         ecount_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ff        <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ff        <= rd_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      elem_ff   <= elem_in;
      ecount_ff <= ecount_in;
      last_ff   <= last_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] nxt;
      if (i == CAPACITY - 1) begin : g_tail
         assign nxt = cell_q[i];
      end else begin : g_body
         assign nxt = cell_q[i+1];
      end
      olpd_cell #(
         .IDX(i)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .next_value   (nxt),
         .front_value  (cell_q[0]),
         .append_value (req_item_value),
         .value        (cell_q[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_elem_value  = elem_ff;
   assign rsp_elem_count  = ecount_ff;
   assign rsp_last_of_run = last_ff;

   `OLPD_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CAP_C)
   `OLPD_ASSERT_ALWAYS(a_busy_blocks, clock, reset, !busy_ff || !req_ready)
   `OLPD_ASSERT_ALWAYS(a_busy_nonempty, clock, reset, !busy_ff || (rd_ff < count_ff))
   `OLPD_ASSERT_NEXT(a_read_starts, clock, reset,
      req_fire && req_func == olpd_pkg::FUNC_READ && count_ff != '0, busy_ff)

endmodule

`default_nettype wire
